@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent that holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bspm_pkg.sv @@
// ----------------------------------------------------------------------------
// bspm_pkg
// types, constants and register codes of the background subtraction marker
// ----------------------------------------------------------------------------
package bspm_pkg;

  localparam int unsigned IMAGE_WIDTH  = 640;
  localparam int unsigned IMAGE_HEIGHT = 480;
  localparam int unsigned BG_DEPTH     = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned BG_ADDR_W    = $clog2(BG_DEPTH);
  localparam int unsigned BG_FILL_W    = $clog2(BG_DEPTH + 1);

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned BG_W   = PIX_W + FRAC_W;
  localparam logic [BG_W-1:0] BG_RESET = BG_W'(128 << FRAC_W);

  localparam int unsigned RATE_W = 16;
  localparam int unsigned THR_W  = 20;
  localparam int unsigned CNT_W  = 19;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam int unsigned LVL_W  = CNT_W + FRAC_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = THR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOT_THRESHOLD    = 3'd0,
    CFG_MOTION_THRESHOLD = 3'd1,
    CFG_BG_RATE          = 3'd2,
    CFG_SMOOTH_RATE      = 3'd3,
    CFG_ALERT_THRESHOLD  = 3'd4,
    CFG_CLICK_THRESHOLD  = 3'd5
  } bspm_cfg_idx_e;

  typedef enum logic [1:0] {
    SM_IDLE,
    SM_ADD,
    SM_DONE
  } bspm_sm_state_e;

  typedef struct packed {
    logic [PIX_W-1:0] hot_threshold;
    logic [PIX_W-1:0] motion_threshold;
    logic [RATE_W-1:0] bg_rate;
    logic [RATE_W-1:0] smooth_rate;
    logic [THR_W-1:0] alert_threshold;
    logic [THR_W-1:0] click_threshold;
  } bspm_cfg_t;

  localparam bspm_cfg_t CFG_RESET = '{
    hot_threshold:    PIX_W'(12),
    motion_threshold: PIX_W'(20),
    bg_rate:          RATE_W'(655),
    smooth_rate:      RATE_W'(3277),
    alert_threshold:  THR_W'(750000),
    click_threshold:  THR_W'(300000)
  };

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             last_in_frame;
  } bspm_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             marked;
    logic             frame_done;
    logic [CNT_W-1:0] hot_count;
    logic [CNT_W-1:0] smoothed_count;
    logic             alert;
    logic             click;
  } bspm_out_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [CNT_W-1:0] count;
  } bspm_sm_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
    logic             alert;
  } bspm_sm_rsp_t;

endpackage

@@ hw/rtl/bspm_ram.sv @@
// ----------------------------------------------------------------------------
// bspm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bspm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bspm_smoother.sv @@
// ----------------------------------------------------------------------------
// bspm_smoother
// frame hot-count smoothing, registered multiply then accumulate in the add state
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bspm_smoother (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bspm_pkg::bspm_cfg_t   cfg_i,
  input  bspm_pkg::bspm_sm_req_t req_i,
  output bspm_pkg::bspm_sm_rsp_t rsp_o
);

  bspm_pkg::bspm_sm_state_e state_q, state_d;

  logic [bspm_pkg::LVL_W-1:0]    lvl_q, lvl_d, lvl_next;
  logic [bspm_pkg::LVL_W-1:0]    p_cnt_q, p_hi_q;
  logic [2*bspm_pkg::FRAC_W-1:0] p_lo_q;
  logic [bspm_pkg::FRAC_W:0]     lo_ceil;
  logic [bspm_pkg::LVL_W+1:0]    lvl_sum;
  logic [bspm_pkg::CNT_W-1:0]    lvl_hi;
  logic [bspm_pkg::FRAC_W-1:0]   lvl_lo;

  assign lvl_hi = lvl_q[bspm_pkg::LVL_W-1:bspm_pkg::FRAC_W];
  assign lvl_lo = lvl_q[bspm_pkg::FRAC_W-1:0];

  // count*rate - ceil(lvl*rate), split so each product stays narrow
  always_ff @(posedge clk_i) begin
    if (state_q == bspm_pkg::SM_IDLE && req_i.start) begin
      p_cnt_q <= req_i.count * cfg_i.smooth_rate;
      p_hi_q  <= lvl_hi * cfg_i.smooth_rate;
      p_lo_q  <= lvl_lo * cfg_i.smooth_rate;
    end
  end

  assign lo_ceil = {1'b0, p_lo_q[2*bspm_pkg::FRAC_W-1:bspm_pkg::FRAC_W]}
                 + (bspm_pkg::FRAC_W+1)'(|p_lo_q[bspm_pkg::FRAC_W-1:0]);

  assign lvl_sum = {2'b00, lvl_q} + {2'b00, p_cnt_q} - {2'b00, p_hi_q}
                 - (bspm_pkg::LVL_W+2)'(lo_ceil);

  assign lvl_next = lvl_sum[bspm_pkg::LVL_W+1] ? '0 : lvl_sum[bspm_pkg::LVL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bspm_pkg::SM_IDLE;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    rsp_o.done  = 1'b0;
    rsp_o.count = lvl_q[bspm_pkg::LVL_W-1:bspm_pkg::FRAC_W];
    rsp_o.alert = {1'b0, lvl_q} > {cfg_i.alert_threshold, {bspm_pkg::FRAC_W{1'b0}}};
    case (state_q)
      bspm_pkg::SM_IDLE: begin
        if (req_i.start) begin
          state_d = bspm_pkg::SM_ADD;
        end
      end
      bspm_pkg::SM_ADD: begin
        lvl_d   = lvl_next;
        state_d = bspm_pkg::SM_DONE;
      end
      bspm_pkg::SM_DONE: begin
        rsp_o.done = 1'b1;
        if (req_i.ack) begin
          state_d = bspm_pkg::SM_IDLE;
        end
      end
      default: begin
        state_d = bspm_pkg::SM_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_lvl_only_in_add, !$stable(lvl_q), $past(state_q) == bspm_pkg::SM_ADD,
               "smoothed level changed outside the add step")

endmodule

@@ hw/rtl/bspm_bg_pipe.sv @@
// ----------------------------------------------------------------------------
// bspm_bg_pipe
// pixel pipeline: background read, update, write back and mark decision
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bspm_bg_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bspm_pkg::bspm_cfg_t    cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bspm_pkg::bspm_in_t     in_data_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output bspm_pkg::bspm_out_t    res_o,
  output bspm_pkg::bspm_sm_req_t sm_req_o,
  input  bspm_pkg::bspm_sm_rsp_t sm_rsp_i
);

  typedef struct packed {
    logic [bspm_pkg::PIX_W-1:0]     red;
    logic [bspm_pkg::PIX_W-1:0]     green;
    logic [bspm_pkg::PIX_W-1:0]     blue;
    logic [bspm_pkg::PIX_W-1:0]     bright;
    logic                           last;
    logic [bspm_pkg::CNT_W-1:0]     count;
    logic [bspm_pkg::BG_ADDR_W-1:0] addr;
    logic                           fresh;
  } bspm_s1_t;

  logic     in_acc, s1_adv, res_valid;
  logic     s1_valid_q, s1_valid_d;
  bspm_s1_t s1_q;
  logic     fwd_q, fwd_d;

  logic [bspm_pkg::BG_W-1:0]      fwd_data_q;
  logic [bspm_pkg::BG_ADDR_W-1:0] pos_q, pos_d;
  logic [bspm_pkg::BG_FILL_W-1:0] fill_q, fill_d, pos_ext;
  logic [bspm_pkg::CNT_W-1:0]     acc_q, acc_d, cnt_new;
  logic [bspm_pkg::PIX_W-1:0]     bright, bg_int, abs_diff;
  logic                           hot, mark;

  logic [bspm_pkg::BG_W-1:0]                      ram_rdata, bg_cur, bg_new;
  logic signed [bspm_pkg::BG_W:0]                 bg_diff;
  logic signed [bspm_pkg::BG_W+bspm_pkg::RATE_W+1:0] bg_prod;
  logic signed [bspm_pkg::BG_W+1:0]               bg_step;
  logic signed [bspm_pkg::BG_W+2:0]               bg_sum;

  // handshake
  assign res_valid   = s1_valid_q && (!s1_q.last || sm_rsp_i.done);
  assign res_valid_o = res_valid;
  assign s1_adv      = res_valid && res_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;

  // accept stage
  always_comb begin
    bright = in_data_i.red_in;
    if (in_data_i.green_in > bright) begin
      bright = in_data_i.green_in;
    end
    if (in_data_i.blue_in > bright) begin
      bright = in_data_i.blue_in;
    end
  end

  assign hot     = bright > cfg_i.hot_threshold;
  assign cnt_new = acc_q + bspm_pkg::CNT_W'(hot && (acc_q != bspm_pkg::COUNT_MAX));
  assign pos_ext = bspm_pkg::BG_FILL_W'(pos_q);

  always_comb begin
    pos_d      = pos_q;
    fill_d     = fill_q;
    acc_d      = acc_q;
    fwd_d      = fwd_q;
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
      fwd_d      = s1_adv && (pos_q == s1_q.addr);
      if (pos_ext == fill_q) begin
        fill_d = fill_q + bspm_pkg::BG_FILL_W'(1);
      end
      if (in_data_i.last_in_frame) begin
        pos_d = '0;
        acc_d = '0;
      end else begin
        acc_d = cnt_new;
        if (pos_q == bspm_pkg::BG_ADDR_W'(bspm_pkg::BG_DEPTH - 1)) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + bspm_pkg::BG_ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      pos_q      <= '0;
      fill_q     <= '0;
      acc_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      fwd_q      <= fwd_d;
      pos_q      <= pos_d;
      fill_q     <= fill_d;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.red    <= in_data_i.red_in;
      s1_q.green  <= in_data_i.green_in;
      s1_q.blue   <= in_data_i.blue_in;
      s1_q.bright <= bright;
      s1_q.last   <= in_data_i.last_in_frame;
      s1_q.count  <= cnt_new;
      s1_q.addr   <= pos_q;
      s1_q.fresh  <= pos_ext >= fill_q;
      fwd_data_q  <= bg_new;
    end
  end

  bspm_ram #(
    .WIDTH (bspm_pkg::BG_W),
    .DEPTH (bspm_pkg::BG_DEPTH)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.addr),
    .wdata_i (bg_new),
    .re_i    (in_acc),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // update stage
  always_comb begin
    if (fwd_q) begin
      bg_cur = fwd_data_q;
    end else if (s1_q.fresh) begin
      bg_cur = bspm_pkg::BG_RESET;
    end else begin
      bg_cur = ram_rdata;
    end
  end

  assign bg_diff = $signed({1'b0, s1_q.bright, {bspm_pkg::FRAC_W{1'b0}}})
                 - $signed({1'b0, bg_cur});
  assign bg_prod = bg_diff * $signed({1'b0, cfg_i.bg_rate});
  assign bg_step = bg_prod[bspm_pkg::BG_W+bspm_pkg::RATE_W+1:bspm_pkg::FRAC_W];
  assign bg_sum  = $signed({3'b000, bg_cur}) + $signed({bg_step[bspm_pkg::BG_W+1], bg_step});

  always_comb begin
    if (bg_sum[bspm_pkg::BG_W+2]) begin
      bg_new = '0;
    end else if (|bg_sum[bspm_pkg::BG_W+1:bspm_pkg::BG_W]) begin
      bg_new = '1;
    end else begin
      bg_new = bg_sum[bspm_pkg::BG_W-1:0];
    end
  end

  assign bg_int   = bg_new[bspm_pkg::BG_W-1:bspm_pkg::FRAC_W];
  assign abs_diff = (s1_q.bright >= bg_int) ? (s1_q.bright - bg_int) : (bg_int - s1_q.bright);
  assign mark     = abs_diff > cfg_i.motion_threshold;

  always_comb begin
    res_o.red_out        = mark ? s1_q.bright : s1_q.red;
    res_o.green_out      = mark ? '0 : s1_q.green;
    res_o.blue_out       = mark ? '0 : s1_q.blue;
    res_o.marked         = mark;
    res_o.frame_done     = s1_q.last;
    res_o.hot_count      = s1_q.last ? s1_q.count : '0;
    res_o.smoothed_count = s1_q.last ? sm_rsp_i.count : '0;
    res_o.alert          = s1_q.last && sm_rsp_i.alert;
    res_o.click          = s1_q.last && ({1'b0, s1_q.count} > cfg_i.click_threshold);
  end

  always_comb begin
    sm_req_o.start = s1_valid_q && s1_q.last;
    sm_req_o.ack   = s1_adv && s1_q.last;
    sm_req_o.count = s1_q.count;
  end

  `ASSERT_CLK(a_pos_in_range, pos_ext < bspm_pkg::BG_FILL_W'(bspm_pkg::BG_DEPTH),
              "pixel position beyond background store")
  `ASSERT_CLK(a_pos_within_fill, pos_ext <= fill_q,
              "pixel position ahead of written background entries")

endmodule

@@ hw/rtl/background_subtraction_pixel_marker_unit.sv @@
// ----------------------------------------------------------------------------
// background subtraction pixel marker, top level
// beats pass pipe and output registers; one pixel beat per cycle unless output stalls; frame ends wait on smoother
// pace set by the background read-modify-write on one ram read and write port
// reset: registers to defaults, counters zero, store reads 128.0 until written
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module background_subtraction_pixel_marker_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bspm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bspm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bspm_pkg::bspm_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output bspm_pkg::bspm_out_t                out_data_o
);

  bspm_pkg::bspm_cfg_t    cfg_q, cfg_d;
  bspm_pkg::bspm_out_t    res, out_q;
  bspm_pkg::bspm_sm_req_t sm_req;
  bspm_pkg::bspm_sm_rsp_t sm_rsp;
  logic                   res_valid, res_ready;
  logic                   out_valid_q, out_valid_d;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bspm_pkg::CFG_HOT_THRESHOLD: begin
          cfg_d.hot_threshold = cfg_wdata_i[bspm_pkg::PIX_W-1:0];
        end
        bspm_pkg::CFG_MOTION_THRESHOLD: begin
          cfg_d.motion_threshold = cfg_wdata_i[bspm_pkg::PIX_W-1:0];
        end
        bspm_pkg::CFG_BG_RATE: begin
          cfg_d.bg_rate = cfg_wdata_i[bspm_pkg::RATE_W-1:0];
        end
        bspm_pkg::CFG_SMOOTH_RATE: begin
          cfg_d.smooth_rate = cfg_wdata_i[bspm_pkg::RATE_W-1:0];
        end
        bspm_pkg::CFG_ALERT_THRESHOLD: begin
          cfg_d.alert_threshold = cfg_wdata_i[bspm_pkg::THR_W-1:0];
        end
        bspm_pkg::CFG_CLICK_THRESHOLD: begin
          cfg_d.click_threshold = cfg_wdata_i[bspm_pkg::THR_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  bspm_bg_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .sm_req_o    (sm_req),
    .sm_rsp_i    (sm_rsp)
  );

  bspm_smoother u_smoother (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (sm_req),
    .rsp_o  (sm_rsp)
  );

  // output register
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= bspm_pkg::CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_frame_fields_idle, out_valid_q && !out_q.frame_done,
               out_q.hot_count == '0 && out_q.smoothed_count == '0 && !out_q.alert
               && !out_q.click,
               "frame fields set on a beat that does not end a frame")

endmodule
